// ===== rtl/keyed_linked_deque_engine_defines.svh =====
// ----------------------------------------------------------------------------
// keyed_linked_deque_engine_defines
// Assertion macros shared by the deque engine RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clock and reset in the calling scope.
`ifndef KEYED_LINKED_DEQUE_ENGINE_DEFINES_SVH
`define KEYED_LINKED_DEQUE_ENGINE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define KLD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define KLD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/kld_pkg.sv =====
// ----------------------------------------------------------------------------
// kld_pkg
// Shared constants, request codes and types of the keyed linked deque engine.
// ----------------------------------------------------------------------------
package kld_pkg;

   localparam int ENTRIES_DEF      = 64;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int DATA_W           = 32;
   localparam int TYPE_W           = 4;

   localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT   = 4'd0;
   localparam logic [TYPE_W-1:0] REQ_PUSH_BACK    = 4'd1;
   localparam logic [TYPE_W-1:0] REQ_POP_FRONT    = 4'd2;
   localparam logic [TYPE_W-1:0] REQ_POP_BACK     = 4'd3;
   localparam logic [TYPE_W-1:0] REQ_SEARCH       = 4'd4;
   localparam logic [TYPE_W-1:0] REQ_INSERT_BEFORE = 4'd5;
   localparam logic [TYPE_W-1:0] REQ_INSERT_AFTER = 4'd6;
   localparam logic [TYPE_W-1:0] REQ_REMOVE       = 4'd7;
   localparam logic [TYPE_W-1:0] REQ_ITER_FWD     = 4'd8;
   localparam logic [TYPE_W-1:0] REQ_ITER_BACK    = 4'd9;

   typedef struct packed {
      logic take;
      logic give;
   } kld_free_ctl_type;

endpackage

// ===== rtl/keyed_linked_deque_engine.sv =====
// ----------------------------------------------------------------------------
// keyed_linked_deque_engine
// Bounded doubly linked deque of key and payload entries with a free list.
// ----------------------------------------------------------------------------
// A request enters on req_valid/req_ready and is worked on alone; req_ready
// is high only while the sequencer is idle. One response leaves on
// rsp_valid/rsp_ready for every request, held in an output register, so a
// new request may be accepted while the previous response waits.
// A search walks the list from the head and visits at most ENTRIES
// entries. The next request can be accepted once the response is
// registered. The link and data stores have a single registered read
// port; an insert, pop or remove reads the links it needs before it
// writes, while a push takes its neighbors from the head and tail
// registers. The single key comparator checks one entry a cycle.
// Reset empties the deque and frees all slots at once; no clearing pass
// is needed. A stalled response stays in the output register; the next
// request still runs and then holds in its final state until it is free.
// ----------------------------------------------------------------------------
`include "keyed_linked_deque_engine_defines.svh"

module keyed_linked_deque_engine import kld_pkg::*; #(
   parameter int ENTRIES      = ENTRIES_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [TYPE_W-1:0]              req_type,
   input  logic signed [DATA_W-1:0]       req_key,
   input  logic [DATA_W-1:0]              req_payload,
   input  logic [$clog2(ENTRIES+1)-1:0]   req_handle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic signed [DATA_W-1:0]       rsp_out_key,
   output logic [DATA_W-1:0]              rsp_out_payload,
   output logic [$clog2(ENTRIES+1)-1:0]   rsp_out_handle
);

   localparam int IW = $clog2(ENTRIES);
   localparam int HW = $clog2(ENTRIES + 1);
   localparam logic [HW-1:0] NULL_H = HW'(ENTRIES);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RDH   = 4'd2;
   localparam logic [3:0] S_LINKA = 4'd3;
   localparam logic [3:0] S_LINKB = 4'd4;
   localparam logic [3:0] S_RDT   = 4'd5;
   localparam logic [3:0] S_ITER  = 4'd6;
   localparam logic [3:0] S_SRCH  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]               state_ff, state_in;
   logic [HW-1:0]            head_ff, head_in, tail_ff, tail_in;
   logic [ENTRIES-1:0]       live_ff, live_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [TYPE_W-1:0]        op_type_ff, op_type_in;
   logic [DATA_W-1:0]        op_key_ff, op_key_in;
   logic [PAYLOAD_BITS-1:0]  op_pay_ff, op_pay_in;
   logic [HW-1:0]            op_h_ff, op_h_in;
   logic                     op_live_ff, op_live_in;
   logic [HW-1:0]            cur_ff, cur_in, p_ff, p_in, n_ff, n_in, cnt_ff, cnt_in;
   logic [IW-1:0]            new_ff, new_in;
   logic                     res_ok_ff, res_ok_in;
   logic [DATA_W-1:0]        res_key_ff, res_key_in, res_pay_ff, res_pay_in;
   logic [HW-1:0]            res_h_ff, res_h_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic [DATA_W-1:0]        rsp_key_ff, rsp_key_in, rsp_pay_ff, rsp_pay_in;
   logic [HW-1:0]            rsp_h_ff, rsp_h_in;

   logic [IW-1:0]            rd_addr;
   logic                     next_we, prev_we, data_we;
   logic [IW-1:0]            next_wa, prev_wa;
   logic [HW-1:0]            next_wd, prev_wd;
   logic [HW-1:0]            next_q, prev_q;
   logic [DATA_W-1:0]        key_q;
   logic [PAYLOAD_BITS-1:0]  pay_q;
   logic [PAYLOAD_BITS+DATA_W-1:0] pay_q_wide;
   logic [PAYLOAD_BITS+DATA_W-1:0] pay_in_wide;
   logic [DATA_W-1:0]        pay_out;

   kld_free_ctl_type         free_ctl;
   logic [IW-1:0]            free_slot;
   logic [HW-1:0]            free_count;

   logic [HW-1:0]            end_pick, iter_t;
   logic                     live_op_h, live_end, live_iter, live_head, live_next;

   assign pay_q_wide  = {{DATA_W{1'b0}}, pay_q};
   assign pay_out     = pay_q_wide[DATA_W-1:0];
   assign pay_in_wide = {{PAYLOAD_BITS{1'b0}}, req_payload};

   assign end_pick = (op_type_ff == REQ_POP_FRONT || op_type_ff == REQ_ITER_FWD) ?
                     head_ff : tail_ff;
   assign iter_t   = (op_h_ff == NULL_H) ? end_pick : op_h_ff;

   // The ends and every link of a live entry are either null or live.
   assign live_op_h = op_live_ff;
   assign live_end  = (end_pick < NULL_H);
   assign live_iter = (op_h_ff == NULL_H) ? live_end : live_op_h;
   assign live_head = (head_ff < NULL_H);
   assign live_next = (next_q < NULL_H);

   kld_free #(.ENTRIES(ENTRIES)) u_free (
      .clock     (clock),
      .reset     (reset),
      .ctl       (free_ctl),
      .give_slot (cur_ff[IW-1:0]),
      .slot      (free_slot),
      .count     (free_count)
   );

   kld_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_next (
      .clock (clock), .wr_en (next_we), .wr_addr (next_wa), .wr_data (next_wd),
      .rd_addr (rd_addr), .rd_data (next_q)
   );

   kld_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_prev (
      .clock (clock), .wr_en (prev_we), .wr_addr (prev_wa), .wr_data (prev_wd),
      .rd_addr (rd_addr), .rd_data (prev_q)
   );

   kld_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_key (
      .clock (clock), .wr_en (data_we), .wr_addr (new_ff), .wr_data (op_key_ff),
      .rd_addr (rd_addr), .rd_data (key_q)
   );

   kld_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(ENTRIES)) u_pay (
      .clock (clock), .wr_en (data_we), .wr_addr (new_ff), .wr_data (op_pay_ff),
      .rd_addr (rd_addr), .rd_data (pay_q)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      live_in      = live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op_type_in   = op_type_ff;
      op_key_in    = op_key_ff;
      op_pay_in    = op_pay_ff;
      op_h_in      = op_h_ff;
      op_live_in   = op_live_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      new_in       = new_ff;
      res_ok_in    = res_ok_ff;
      res_key_in   = res_key_ff;
      res_pay_in   = res_pay_ff;
      res_h_in     = res_h_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_h_in     = rsp_h_ff;
      rd_addr      = '0;
      next_we      = 1'b0;
      prev_we      = 1'b0;
      data_we      = 1'b0;
      next_wa      = '0;
      prev_wa      = '0;
      next_wd      = '0;
      prev_wd      = '0;
      free_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_type_in = req_type;
               op_key_in  = req_key;
               op_pay_in  = pay_in_wide[PAYLOAD_BITS-1:0];
               op_h_in    = req_handle;
               op_live_in = (req_handle < NULL_H) && live_ff[req_handle[IW-1:0]];
               state_in   = S_DISP;
            end
         end
         S_DISP: begin
            res_ok_in  = 1'b0;
            res_key_in = '0;
            res_pay_in = '0;
            res_h_in   = NULL_H;
            new_in     = free_slot;
            cnt_in     = '0;
            state_in   = S_DONE;
            case (op_type_ff)
               REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                  if (free_count != '0) begin
                     p_in     = (op_type_ff == REQ_PUSH_FRONT) ? NULL_H : tail_ff;
                     n_in     = (op_type_ff == REQ_PUSH_FRONT) ? head_ff : NULL_H;
                     state_in = S_LINKA;
                  end
               end
               REQ_INSERT_BEFORE, REQ_INSERT_AFTER: begin
                  if (live_op_h && free_count != '0) begin
                     rd_addr  = op_h_ff[IW-1:0];
                     state_in = S_RDH;
                  end
               end
               REQ_POP_FRONT, REQ_POP_BACK: begin
                  if (live_end) begin
                     rd_addr  = end_pick[IW-1:0];
                     cur_in   = end_pick;
                     state_in = S_RDT;
                  end
               end
               REQ_REMOVE: begin
                  if (live_op_h) begin
                     rd_addr  = op_h_ff[IW-1:0];
                     cur_in   = op_h_ff;
                     state_in = S_RDT;
                  end
               end
               REQ_ITER_FWD, REQ_ITER_BACK: begin
                  if (live_iter) begin
                     rd_addr  = iter_t[IW-1:0];
                     state_in = S_ITER;
                  end
               end
               REQ_SEARCH: begin
                  if (live_head) begin
                     rd_addr  = head_ff[IW-1:0];
                     cur_in   = head_ff;
                     state_in = S_SRCH;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_RDH: begin
            if (op_type_ff == REQ_INSERT_BEFORE) begin
               p_in = prev_q;
               n_in = op_h_ff;
            end else begin
               p_in = op_h_ff;
               n_in = next_q;
            end
            state_in = S_LINKA;
         end
         S_LINKA: begin
            data_we         = 1'b1;
            next_we         = 1'b1;
            next_wa         = new_ff;
            next_wd         = n_ff;
            prev_we         = 1'b1;
            prev_wa         = new_ff;
            prev_wd         = p_ff;
            live_in[new_ff] = 1'b1;
            free_ctl.take   = 1'b1;
            state_in        = S_LINKB;
         end
         S_LINKB: begin
            if (p_ff < NULL_H) begin
               next_we = 1'b1;
               next_wa = p_ff[IW-1:0];
               next_wd = HW'(new_ff);
            end else begin
               head_in = HW'(new_ff);
            end
            if (n_ff < NULL_H) begin
               prev_we = 1'b1;
               prev_wa = n_ff[IW-1:0];
               prev_wd = HW'(new_ff);
            end else begin
               tail_in = HW'(new_ff);
            end
            res_ok_in = 1'b1;
            res_h_in  = HW'(new_ff);
            state_in  = S_DONE;
         end
         S_RDT: begin
            if (prev_q < NULL_H) begin
               next_we = 1'b1;
               next_wa = prev_q[IW-1:0];
               next_wd = next_q;
            end else begin
               head_in = next_q;
            end
            if (next_q < NULL_H) begin
               prev_we = 1'b1;
               prev_wa = next_q[IW-1:0];
               prev_wd = prev_q;
            end else begin
               tail_in = prev_q;
            end
            live_in[cur_ff[IW-1:0]] = 1'b0;
            free_ctl.give = 1'b1;
            res_ok_in     = 1'b1;
            if (op_type_ff != REQ_REMOVE) begin
               res_key_in = key_q;
               res_pay_in = pay_out;
            end
            state_in = S_DONE;
         end
         S_ITER: begin
            res_ok_in  = 1'b1;
            res_key_in = key_q;
            res_pay_in = pay_out;
            res_h_in   = (op_type_ff == REQ_ITER_FWD) ? next_q : prev_q;
            state_in   = S_DONE;
         end
         S_SRCH: begin
            if (key_q == op_key_ff) begin
               res_ok_in  = 1'b1;
               res_key_in = key_q;
               res_pay_in = pay_out;
               res_h_in   = cur_ff;
               state_in   = S_DONE;
            end else if (cnt_ff == HW'(ENTRIES - 1) || !live_next) begin
               state_in = S_DONE;
            end else begin
               rd_addr = next_q[IW-1:0];
               cur_in  = next_q;
               cnt_in  = cnt_ff + HW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_key_in   = res_key_ff;
               rsp_pay_in   = res_pay_ff;
               rsp_h_in     = res_h_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_H;
         tail_ff      <= NULL_H;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_type_ff <= op_type_in;
      op_key_ff  <= op_key_in;
      op_pay_ff  <= op_pay_in;
      op_h_ff    <= op_h_in;
      op_live_ff <= op_live_in;
      cur_ff     <= cur_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      cnt_ff     <= cnt_in;
      new_ff     <= new_in;
      res_ok_ff  <= res_ok_in;
      res_key_ff <= res_key_in;
      res_pay_ff <= res_pay_in;
      res_h_ff   <= res_h_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_key_ff <= rsp_key_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_h_ff   <= rsp_h_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_out_handle  = rsp_h_ff;

   `KLD_ASSERT_ALWAYS(a_ends_agree, (head_ff == NULL_H) == (tail_ff == NULL_H), "head/tail disagree")
   `KLD_ASSERT_IMPLY(a_empty_all_free, state_ff == S_IDLE && head_ff == NULL_H, free_count == NULL_H, "empty but slots held")
   `KLD_ASSERT_IMPLY(a_slot_balance, state_ff == S_IDLE, ($countones(live_ff) + int'(free_count)) == ENTRIES, "live and free slots do not add up")

endmodule

// ===== rtl/kld_ram.sv =====
// ----------------------------------------------------------------------------
// kld_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kld_free.sv =====
// ----------------------------------------------------------------------------
// kld_free
// Free slot allocator: a stack in RAM plus a fill mark for never used slots.
// ----------------------------------------------------------------------------
module kld_free import kld_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kld_free_ctl_type               ctl,
   input  logic [$clog2(ENTRIES)-1:0]     give_slot,
   output logic [$clog2(ENTRIES)-1:0]     slot,
   output logic [$clog2(ENTRIES+1)-1:0]   count
);

   localparam int IW = $clog2(ENTRIES);
   localparam int HW = $clog2(ENTRIES + 1);

   logic [HW-1:0] count_ff, count_in;
   logic [HW-1:0] fresh_ff, fresh_in;
   logic [IW-1:0] stack_q;
   logic [HW-1:0] count_m1;
   logic [HW-1:0] fresh_slot;

   assign count_m1   = count_ff - HW'(1);
   assign fresh_slot = HW'(ENTRIES) - count_ff;

   kld_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_stack (
      .clock   (clock),
      .wr_en   (ctl.give),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (give_slot),
      .rd_addr (count_m1[IW-1:0]),
      .rd_data (stack_q)
   );

   assign slot  = (count_ff <= fresh_ff) ? fresh_slot[IW-1:0] : stack_q;
   assign count = count_ff;

   always_comb begin
      count_in = count_ff;
      fresh_in = fresh_ff;
      if (ctl.take) begin
         count_in = count_m1;
         if (count_ff <= fresh_ff) begin
            fresh_in = count_m1;
         end
      end else if (ctl.give) begin
         count_in = count_ff + HW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= HW'(ENTRIES);
         fresh_ff <= HW'(ENTRIES);
      end else begin
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

// ===== tb/sv/tb_keyed_linked_deque_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyed_linked_deque_engine
// Randomized request and response test of the keyed linked deque engine.
// ----------------------------------------------------------------------------
// A directed sequence covers pushes to a full deque, pops of an empty one,
// bad and null handles, unknown codes and search hits and misses. Random
// traffic then favors valid handles and a small key set so that the walks,
// inserts and removes reach deep into the list. A behavioral deque predicts
// every response, and responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_keyed_linked_deque_engine import kld_pkg::*;;

   localparam int NSLOT = 64;
   localparam logic [6:0] NULL_H = 7'd64;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [31:0]       key;
      logic [31:0]       payload;
      logic [6:0]        handle;
   } request_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] key;
      logic [31:0] payload;
      logic [6:0]  handle;
   } response_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [TYPE_W-1:0] req_type;
   logic signed [31:0] req_key;
   logic [31:0] req_payload;
   logic [6:0] req_handle;
   logic rsp_ok;
   logic signed [31:0] rsp_out_key;
   logic [31:0] rsp_out_payload;
   logic [6:0] rsp_out_handle;

   keyed_linked_deque_engine i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_key(req_key), .req_payload(req_payload), .req_handle(req_handle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_out_key(rsp_out_key), .rsp_out_payload(rsp_out_payload),
      .rsp_out_handle(rsp_out_handle)
   );

   // Behavioral copy of the deque.
   logic [6:0]  nxt [NSLOT];
   logic [6:0]  prv [NSLOT];
   logic [31:0] ekey [NSLOT];
   logic [31:0] epay [NSLOT];
   bit          live [NSLOT];
   logic [6:0]  head, tail;
   logic [5:0]  free_slots [NSLOT];
   int          free_n;
   int          live_n;

   request_type  pending_q[$];
   response_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 0;

   function automatic bit is_live(logic [6:0] h);
      return h < NULL_H && live[h[5:0]];
   endfunction

   function automatic logic [6:0] link_new(logic [6:0] p, logic [6:0] n,
                                           logic [31:0] k, logic [31:0] d);
      logic [6:0] h;
      free_n--;
      h = {1'b0, free_slots[free_n]};
      ekey[h] = k; epay[h] = d; live[h] = 1; prv[h] = p; nxt[h] = n;
      if (p != NULL_H) nxt[p] = h; else head = h;
      if (n != NULL_H) prv[n] = h; else tail = h;
      live_n++;
      return h;
   endfunction

   function automatic void unlink_slot(logic [6:0] h);
      logic [6:0] p, n;
      p = prv[h]; n = nxt[h];
      if (p != NULL_H) nxt[p] = n; else head = n;
      if (n != NULL_H) prv[n] = p; else tail = p;
      live[h] = 0;
      free_slots[free_n] = h[5:0];
      free_n++;
      live_n--;
   endfunction

   function automatic response_type apply_request(request_type r);
      response_type o;
      logic [6:0] t;
      o = '{ok: 0, key: 0, payload: 0, handle: NULL_H};
      case (r.kind)
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (free_n > 0) begin
               o.handle = (r.kind == REQ_PUSH_FRONT) ?
                  link_new(NULL_H, head, r.key, r.payload) :
                  link_new(tail, NULL_H, r.key, r.payload);
               o.ok = 1;
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            t = (r.kind == REQ_POP_FRONT) ? head : tail;
            if (is_live(t)) begin
               o.ok = 1; o.key = ekey[t]; o.payload = epay[t];
               unlink_slot(t);
            end
         end
         REQ_SEARCH: begin
            t = head;
            for (int i = 0; i < NSLOT && is_live(t); i++) begin
               if (ekey[t] == r.key) begin
                  o.ok = 1; o.key = ekey[t]; o.payload = epay[t]; o.handle = t;
                  break;
               end
               t = nxt[t];
            end
         end
         REQ_INSERT_BEFORE, REQ_INSERT_AFTER: begin
            if (is_live(r.handle) && free_n > 0) begin
               o.handle = (r.kind == REQ_INSERT_BEFORE) ?
                  link_new(prv[r.handle], r.handle, r.key, r.payload) :
                  link_new(r.handle, nxt[r.handle], r.key, r.payload);
               o.ok = 1;
            end
         end
         REQ_REMOVE: begin
            if (is_live(r.handle)) begin
               unlink_slot(r.handle);
               o.ok = 1;
            end
         end
         REQ_ITER_FWD, REQ_ITER_BACK: begin
            t = r.handle;
            if (t == NULL_H) t = (r.kind == REQ_ITER_FWD) ? head : tail;
            if (is_live(t)) begin
               o.ok = 1; o.key = ekey[t]; o.payload = epay[t];
               o.handle = (r.kind == REQ_ITER_FWD) ? nxt[t] : prv[t];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic int gap_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0; req_type <= '0; req_key <= '0;
         req_payload <= '0; req_handle <= '0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (pending_q.size() > 0) begin
            request_type r;
            r = pending_q.pop_front();
            req_valid <= 1; req_type <= r.kind; req_key <= r.key;
            req_payload <= r.payload; req_handle <= r.handle;
            send_gap <= gap_length();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor: prediction on acceptance, comparison on response.
   int stall = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(apply_request('{req_type, req_key, req_payload,
                                                 req_handle}));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               response_type e;
               e = expected_q.pop_front();
               if (rsp_ok !== e.ok) begin
                  $error("ok: expected %0d, got %0d", e.ok, rsp_ok); errors++;
               end
               if (rsp_out_key !== e.key) begin
                  $error("out_key: expected %0d, got %0d", $signed(e.key),
                         rsp_out_key);
                  errors++;
               end
               if (rsp_out_payload !== e.payload) begin
                  $error("out_payload: expected %h, got %h", e.payload,
                         rsp_out_payload);
                  errors++;
               end
               if (rsp_out_handle !== e.handle) begin
                  $error("out_handle: expected %0d, got %0d", e.handle,
                         rsp_out_handle);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if ($urandom_range(0, 3) == 0) stall <= gap_length();
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus is generated against a shadow count of live slots so that
   // handles mostly point at live entries.
   bit   shadow_live [NSLOT];
   int   shadow_n;
   logic [5:0] shadow_free [NSLOT];
   int   shadow_free_n;

   function automatic logic [6:0] pick_handle();
      int sel;
      logic [6:0] h;
      sel = $urandom_range(0, 99);
      if (sel < 6) return NULL_H;
      if (sel < 10) return 7'($urandom_range(65, 127));
      if (sel < 16 || shadow_n == 0) return 7'($urandom_range(0, 63));
      do h = 7'($urandom_range(0, 63)); while (!shadow_live[h]);
      return h;
   endfunction

   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return 32'($urandom_range(0, 15));
      if (sel == 6) return 32'h8000_0000;
      if (sel == 7) return 32'h7fff_ffff;
      return $urandom();
   endfunction

   task automatic queue_request(logic [TYPE_W-1:0] k, logic [31:0] key,
                                logic [31:0] d, logic [6:0] h);
      pending_q.push_back('{k, key, d, h});
      // Run the prediction only to steer handle choice.
      void'(apply_request('{k, key, d, h}));
      shadow_n = live_n;
      for (int i = 0; i < NSLOT; i++) shadow_live[i] = live[i];
   endtask

   initial begin
      int n, sel, target;
      logic [TYPE_W-1:0] k;
      reset = 1;
      rsp_ready = 0; req_valid = 0; req_type = '0; req_key = '0;
      req_payload = '0; req_handle = '0;
      // Steering copy uses the predictor state, which is put back to reset state afterwards.
      head = NULL_H; tail = NULL_H; free_n = NSLOT; live_n = 0;
      for (int i = 0; i < NSLOT; i++) begin
         live[i] = 0; free_slots[i] = 6'(NSLOT - 1 - i);
      end
      shadow_n = 0;
      for (int i = 0; i < NSLOT; i++) shadow_live[i] = 0;

      queue_request(REQ_POP_FRONT, 0, 0, NULL_H);
      queue_request(REQ_POP_BACK, 0, 0, NULL_H);
      queue_request(REQ_ITER_FWD, 0, 0, NULL_H);
      queue_request(REQ_ITER_BACK, 0, 0, NULL_H);
      queue_request(REQ_REMOVE, 0, 0, 7'd0);
      queue_request(REQ_INSERT_AFTER, 1, 1, 7'd0);
      queue_request(REQ_PUSH_FRONT, 32'h8000_0000, 32'hffff_ffff, 7'd0);
      queue_request(REQ_PUSH_BACK, 32'h7fff_ffff, 32'h0, 7'd127);
      queue_request(REQ_INSERT_BEFORE, 32'hffff_ffff, 32'haaaa_5555, 7'd1);
      queue_request(REQ_INSERT_AFTER, 5, 32'h5555_aaaa, 7'd0);
      queue_request(REQ_SEARCH, 32'h7fff_ffff, 0, 7'd0);
      queue_request(REQ_SEARCH, 12345, 0, 7'd0);
      queue_request(REQ_ITER_FWD, 0, 0, NULL_H);
      queue_request(REQ_ITER_BACK, 0, 0, 7'd1);
      queue_request(REQ_ITER_FWD, 0, 0, 7'd100);
      queue_request(REQ_INSERT_BEFORE, 0, 0, NULL_H);
      queue_request(REQ_REMOVE, 0, 0, 7'd65);
      queue_request(4'd10, 0, 0, 7'd0);
      queue_request(4'd15, 32'hffff_ffff, 32'hffff_ffff, 7'h7f);
      for (int i = 0; i < 62; i++)
         queue_request(REQ_PUSH_BACK, 32'(i), $urandom(), 7'd0);
      queue_request(REQ_PUSH_FRONT, 1, 1, 7'd0);
      queue_request(REQ_INSERT_AFTER, 1, 1, 7'd0);
      queue_request(REQ_SEARCH, 61, 0, 7'd0);
      queue_request(REQ_REMOVE, 0, 0, 7'd3);

      n = 0;
      target = 0;
      while (n < 1300) begin
         // Pick a filling, mixed or draining phase every 200 requests.
         if (n % 200 == 0) target = $urandom_range(0, 2);
         sel = $urandom_range(0, 99);
         if (sel < 25) k = (target == 0 || $urandom_range(0, 1)) ?
                           REQ_PUSH_BACK : REQ_PUSH_FRONT;
         else if (sel < 40) k = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
         else if (sel < 52) k = REQ_SEARCH;
         else if (sel < 66) k = $urandom_range(0, 1) ? REQ_INSERT_BEFORE
                                                   : REQ_INSERT_AFTER;
         else if (sel < 76) k = REQ_REMOVE;
         else if (sel < 96) k = $urandom_range(0, 1) ? REQ_ITER_FWD : REQ_ITER_BACK;
         else k = 4'($urandom_range(10, 15));
         if (target == 2 && (k == REQ_PUSH_BACK || k == REQ_PUSH_FRONT))
            k = REQ_POP_FRONT;
         queue_request(k, pick_key(), $urandom(), pick_handle());
         n++;
      end

      // Restore the predictor to reset state for the monitor.
      head = NULL_H; tail = NULL_H; free_n = NSLOT; live_n = 0;
      for (int i = 0; i < NSLOT; i++) begin
         live[i] = 0; free_slots[i] = 6'(NSLOT - 1 - i);
      end

      repeat (2) @(posedge clock);
      reset <= 0;
      wait (pending_q.size() == 0 && !req_valid && expected_q.size() == 0);
      repeat (80) @(posedge clock);
      stim_done = 1;
   end

   initial begin
      wait (stim_done || idle_cycles >= IDLE_LIMIT);
      if (!stim_done) begin
         $display("tb_keyed_linked_deque_engine: FAIL");
      end else if (errors == 0 && expected_q.size() == 0) begin
         $display("tb_keyed_linked_deque_engine: PASS");
      end else begin
         if (expected_q.size() != 0) $error("responses missing at end");
         $display("tb_keyed_linked_deque_engine: FAIL");
      end
      $finish;
   end

endmodule
